[hw/rtl/spc_pkg.sv]
// spc_pkg: shared types and constants for the sphere placement contact check
// used by spc_store, spc_dist and sphere_placement_contact_check
package spc_pkg;

  localparam int MAX_SPHERES_DEF = 8192;
  localparam int COORD_BITS_DEF  = 18;

  localparam int RADIUS_W    = 16;
  localparam int TARGET_W    = 14;
  localparam int COUNT_OUT_W = 14;
  localparam int SPAN_W      = RADIUS_W + 1;
  localparam int LIMIT_W     = 2 * SPAN_W;
  localparam int CFG_DATA_W  = RADIUS_W;
  localparam int CFG_IDX_W   = 1;

  localparam logic [RADIUS_W-1:0] RADIUS_RST = RADIUS_W'(500);
  localparam logic [TARGET_W-1:0] TARGET_RST = TARGET_W'(6000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS = 1'b0,
    CFG_TARGET = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic hit_valid;
    logic hit;
    logic busy;
  } dist_status_t;

endpackage

[hw/rtl/spc_store.sv]
// spc_store: centre store, one write port and one registered read port
// no dependencies beyond spc_pkg
module spc_store
  import spc_pkg::*;
#(
  parameter int ADDR_W = 13,
  parameter int DATA_W = 54
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[hw/rtl/spc_dist.sv]
// spc_dist: pipelined squared-distance unit, one stored centre per cycle
// depends on spc_pkg for the status struct and limit width
module spc_dist
  import spc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  flush,
  input  logic                  in_valid,
  input  logic [COORD_BITS-1:0] cand_x,
  input  logic [COORD_BITS-1:0] cand_y,
  input  logic [COORD_BITS-1:0] cand_z,
  input  logic [COORD_BITS-1:0] ref_x,
  input  logic [COORD_BITS-1:0] ref_y,
  input  logic [COORD_BITS-1:0] ref_z,
  input  logic [LIMIT_W-1:0]    limit,
  output dist_status_t          status
);

  localparam int SQ_W  = 2 * COORD_BITS;
  localparam int SUM_W = SQ_W + 2;
  localparam int CMP_W = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;

  logic                  v1, v2, v3;
  logic [COORD_BITS-1:0] dx, dy, dz;
  logic [SQ_W-1:0]       sx, sy, sz;
  logic [SUM_W-1:0]      sum;
  logic                  hit;

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    dx  <= (cand_x >= ref_x) ? cand_x - ref_x : ref_x - cand_x;
    dy  <= (cand_y >= ref_y) ? cand_y - ref_y : ref_y - cand_y;
    dz  <= (cand_z >= ref_z) ? cand_z - ref_z : ref_z - cand_z;
    sx  <= SQ_W'(dx) * SQ_W'(dx);
    sy  <= SQ_W'(dy) * SQ_W'(dy);
    sz  <= SQ_W'(dz) * SQ_W'(dz);
    hit <= CMP_W'(sum) < CMP_W'(limit);
  end

  assign sum = SUM_W'(sx) + SUM_W'(sy) + SUM_W'(sz);

  assign status.hit_valid = v3;
  assign status.hit       = hit;
  assign status.busy      = v1 | v2 | v3;

endmodule

[hw/rtl/sphere_placement_contact_check.sv]
// sphere_placement_contact_check: top level, sequencer, registers and result stage
// depends on spc_pkg, spc_store and spc_dist
//
// input stream carries one candidate centre (x, y, z) per request; output stream
// returns one result per request: accepted, store_full and placed_count.
// the config port writes radius (index 0) and target_count (index 1); the user
// must do so only while idle; the block itself does not enforce it. a candidate
// is checked against every stored centre through one pipelined distance unit fed
// by the store read port, one stored centre per cycle, and the scan stops at the
// first contact. a candidate passes setup, scan (store read, three unit stages),
// write and result; a full store skips scan and write, a contact skips write.
// s_axis_tready is high only while no candidate is in work; a finished result
// waits in the output register while the next candidate may be taken.
// if the receiver stalls and the next result is ready, the sequencer holds.
// reset clears the count and the handshake state and loads radius 500 and
// target 6000; the store contents are not cleared and need no clearing pass.
module sphere_placement_contact_check
  import spc_pkg::*;
#(
  parameter int MAX_SPHERES = MAX_SPHERES_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // cand_x, cand_y, cand_z, zero fill
  input  logic [((3*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // accepted, store_full, placed_count
  output logic [15:0]           m_axis_tdata,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ADDR_W = $clog2(MAX_SPHERES);
  localparam int CNT_W  = $clog2(MAX_SPHERES + 1);
  localparam int CMP_W  = (CNT_W > TARGET_W) ? CNT_W : TARGET_W;
  localparam int DATA_W = 3 * COORD_BITS;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SETUP = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_WRITE = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [RADIUS_W-1:0]   radius;
  logic [TARGET_W-1:0]   target;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      issue_idx;
  logic [COORD_BITS-1:0] cx, cy, cz;
  logic [LIMIT_W-1:0]    limit;
  logic [SPAN_W-1:0]     span;
  logic                  rd_v;
  logic                  res_acc, res_full;
  logic [DATA_W-1:0]     rd_data;
  logic                  full;
  logic                  issuing;
  logic                  out_free;
  logic [CMP_W-1:0]      cnt_ext;
  dist_status_t          dstat;

  assign span     = {radius, 1'b0};
  assign full     = (CMP_W'(count) >= CMP_W'(target)) || (count == CNT_W'(MAX_SPHERES));
  assign issuing  = issue_idx < count;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign cnt_ext  = CMP_W'(count);

  assign s_axis_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RST;
      target <= TARGET_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_RADIUS: radius <= cfg_data;
        CFG_TARGET: target <= cfg_data[TARGET_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_axis_tvalid) state_next = ST_SETUP;
      ST_SETUP: state_next = full ? ST_DONE : ST_SCAN;
      ST_SCAN: begin
        priority if (dstat.hit_valid && dstat.hit) state_next = ST_DONE;
        else if (!issuing && !rd_v && !dstat.busy) state_next = ST_WRITE;
        else state_next = ST_SCAN;
      end
      ST_WRITE: state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      rd_v          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      rd_v  <= (state == ST_SCAN) && issuing && !(dstat.hit_valid && dstat.hit);
      if (state == ST_WRITE) begin
        count <= count + 1'b1;
      end
      if (state == ST_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      cx <= s_axis_tdata[COORD_BITS-1:0];
      cy <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
      cz <= s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
    end
    if (state == ST_SETUP) begin
      limit     <= span * span;
      issue_idx <= '0;
      res_acc   <= 1'b0;
      res_full  <= full;
    end
    if (state == ST_SCAN && issuing) begin
      issue_idx <= issue_idx + 1'b1;
    end
    if (state == ST_WRITE) begin
      res_acc <= 1'b1;
    end
    if (state == ST_DONE && out_free) begin
      m_axis_tdata <= {cnt_ext[COUNT_OUT_W-1:0], res_full, res_acc};
    end
  end

  spc_store #(
    .ADDR_W (ADDR_W),
    .DATA_W (DATA_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (state == ST_WRITE),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_data ({cz, cy, cx}),
    .rd_addr (issue_idx[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  spc_dist #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk      (clk),
    .rst      (rst),
    .flush    (state != ST_SCAN),
    .in_valid (rd_v && (state == ST_SCAN)),
    .cand_x   (cx),
    .cand_y   (cy),
    .cand_z   (cz),
    .ref_x    (rd_data[COORD_BITS-1:0]),
    .ref_y    (rd_data[2*COORD_BITS-1:COORD_BITS]),
    .ref_z    (rd_data[3*COORD_BITS-1:2*COORD_BITS]),
    .limit    (limit),
    .status   (dstat)
  );

endmodule
